### src/ktt_pkg.sv
// ----------------------------------------------------------------------------
// ktt_pkg
// Types and constants shared by the keyed timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ktt_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SLOT_BITS   = $clog2(SLOTS);
  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned KEY_BITS    = 8;
  localparam int unsigned PERIOD_BITS = 32;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_SET_ONE_SHOT = 2'd0,
    OP_SET_PERIODIC = 2'd1,
    OP_STOP         = 2'd2,
    OP_TICK         = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e                    operation;
    logic                   named;
    logic [KEY_BITS-1:0]    key;
    logic [TIME_BITS-1:0]   time_now;
    logic [TIME_BITS-1:0]   fire_time;
    logic [PERIOD_BITS-1:0] period;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 fired_valid;
    logic [SLOT_BITS-1:0] fired_slot;
    logic [KEY_BITS-1:0]  fired_key;
    logic                 any_active;
    logic [TIME_BITS-1:0] next_fire;
    logic                 last;
  } res_t;

  // One slot as held in the table memory.
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [TIME_BITS-1:0]   fire_time;
    logic [PERIOD_BITS-1:0] period;
  } entry_t;

  // One fired timer waiting to be reported.
  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [KEY_BITS-1:0]  key;
  } fire_t;

  // Arm time: now plus period, saturating at the largest time.
  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0]   a,
                                                    logic [PERIOD_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {{(TIME_BITS + 1 - PERIOD_BITS){1'b0}}, b};
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### src/keyed_timer_table_top.sv
// ----------------------------------------------------------------------------
// keyed_timer_table_top
// Table of keyed one-shot and periodic timers kept in a single-port-write,
// registered-read memory; every command is served by one sweep of the table.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+---------------
//   command   | in        | start / busy (taken at       | req_i (req_t)
//             |           |   start && !busy)            |
//   result    | out       | result_valid_o, one cycle    | res_o (res_t)
//
// Sequence: every command sweeps all SLOTS entries through the memory, one
//   entry per cycle, through the registered read stage.
//   Set and stop then commit in S_COMMIT; a tick instead goes to S_EMIT
//   and reports its fired timers one per cycle, or one empty result if
//   none fired.
// Reset: valid and named bits clear at once; no clearing pass is needed.
// Stalls: the receiver cannot stall; each result shows for exactly one
//   cycle, and the registered result lets the next command start meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_timer_table_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ktt_pkg::req_t req_i,
  output logic               result_valid_o,
  output ktt_pkg::res_t      res_o
);

  localparam int unsigned CNT_BITS = ktt_pkg::SLOT_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(ktt_pkg::SLOTS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  ktt_pkg::state_e state_q, state_d;

  ktt_pkg::req_t req_q, req_d;

  // Valid and named bits live in flops so reset clears them in one go.
  logic [ktt_pkg::SLOTS-1:0] valid_q, valid_d;
  logic [ktt_pkg::SLOTS-1:0] named_q, named_d;

  // Sweep address counter and the read-data stage behind it.
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic                          rd_v_q, rd_v_d;
  logic [ktt_pkg::SLOT_BITS-1:0] rd_idx_q, rd_idx_d;

  // Sweep accumulators.
  logic [ktt_pkg::TIME_BITS-1:0]   min_q, min_d;
  logic                            any_q, any_d;
  logic                            match_q, match_d;
  logic [ktt_pkg::SLOT_BITS-1:0]   match_idx_q, match_idx_d;
  logic [ktt_pkg::PERIOD_BITS-1:0] match_per_q, match_per_d;
  logic                            free_q, free_d;
  logic [ktt_pkg::SLOT_BITS-1:0]   free_idx_q, free_idx_d;

  // Fired timers of a tick, in slot order, replayed once the sweep is done.
  ktt_pkg::fire_t                fifo_q [ktt_pkg::SLOTS];
  logic                          push;
  ktt_pkg::fire_t                push_data;
  logic [CNT_BITS-1:0]           fire_cnt_q, fire_cnt_d;
  logic [ktt_pkg::SLOT_BITS-1:0] out_ptr_q, out_ptr_d;

  // Registered result.
  ktt_pkg::res_t res_q, res_d;
  logic          res_valid_q, res_valid_d;

  // Table memory.
  ktt_pkg::entry_t               mem [ktt_pkg::SLOTS];
  ktt_pkg::entry_t               rdata_q;
  logic                          mem_re;
  logic [ktt_pkg::SLOT_BITS-1:0] mem_raddr;
  logic                          mem_we;
  logic [ktt_pkg::SLOT_BITS-1:0] mem_waddr;
  ktt_pkg::entry_t               mem_wdata;

  logic sweep_last;
  logic emit_last;

  assign busy           = (state_q != ktt_pkg::S_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  assign mem_re     = (state_q == ktt_pkg::S_SCAN) && (cnt_q != CNT_END);
  assign mem_raddr  = cnt_q[ktt_pkg::SLOT_BITS-1:0];
  assign sweep_last = rd_v_q && (rd_idx_q == ktt_pkg::SLOT_BITS'(ktt_pkg::SLOTS - 1));
  assign emit_last  = (fire_cnt_q == '0) ||
                      (({1'b0, out_ptr_q} + CNT_BITS'(1)) == fire_cnt_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ktt_pkg::S_IDLE: begin
        if (start) begin
          state_d = ktt_pkg::S_SCAN;
        end
      end
      ktt_pkg::S_SCAN: begin
        if (sweep_last) begin
          state_d = (req_q.operation == ktt_pkg::OP_TICK) ? ktt_pkg::S_EMIT
                                                          : ktt_pkg::S_COMMIT;
        end
      end
      ktt_pkg::S_COMMIT: begin
        state_d = ktt_pkg::S_IDLE;
      end
      ktt_pkg::S_EMIT: begin
        if (emit_last) begin
          state_d = ktt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ktt_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    logic                            v;
    logic                            nm;
    logic                            fired;
    logic                            keep;
    logic                            hit;
    logic [ktt_pkg::TIME_BITS-1:0]   rearm;
    logic [ktt_pkg::TIME_BITS-1:0]   cand;
    logic [ktt_pkg::TIME_BITS-1:0]   t_set;
    logic [ktt_pkg::SLOT_BITS-1:0]   s;
    logic                            ok;
    logic [ktt_pkg::PERIOD_BITS-1:0] per_new;
    ktt_pkg::status_e                st;

    req_d       = req_q;
    valid_d     = valid_q;
    named_d     = named_q;
    cnt_d       = cnt_q;
    rd_v_d      = mem_re;
    rd_idx_d    = mem_raddr;
    min_d       = min_q;
    any_d       = any_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_per_d = match_per_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    fire_cnt_d  = fire_cnt_q;
    out_ptr_d   = out_ptr_q;
    push        = 1'b0;
    push_data   = '0;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = rdata_q;
    res_d       = '0;
    res_valid_d = 1'b0;

    v       = valid_q[rd_idx_q];
    nm      = named_q[rd_idx_q];
    rearm   = ktt_pkg::sat_add(req_q.time_now, rdata_q.period);
    fired   = v && (rdata_q.fire_time < req_q.time_now);
    keep    = 1'b0;
    hit     = 1'b0;
    cand    = rdata_q.fire_time;
    t_set   = (req_q.operation == ktt_pkg::OP_SET_ONE_SHOT)
              ? req_q.fire_time
              : ktt_pkg::sat_add(req_q.time_now, req_q.period);
    s       = match_q ? match_idx_q : free_idx_q;
    ok      = match_q || free_q;
    per_new = '0;
    st      = ktt_pkg::ST_NONE;

    unique case (state_q)
      ktt_pkg::S_IDLE: begin
        if (start) begin
          req_d      = req_i;
          cnt_d      = '0;
          min_d      = ktt_pkg::TIME_MAX;
          any_d      = 1'b0;
          match_d    = 1'b0;
          free_d     = 1'b0;
          fire_cnt_d = '0;
          out_ptr_d  = '0;
        end
      end

      ktt_pkg::S_SCAN: begin
        if (mem_re) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end
        if (rd_v_q) begin
          if (req_q.operation == ktt_pkg::OP_TICK) begin
            // Fire: drop one-shot slots, re-arm periodic ones.
            if (fired) begin
              push           = 1'b1;
              push_data.slot = rd_idx_q;
              push_data.key  = nm ? rdata_q.key : '0;
              fire_cnt_d     = fire_cnt_q + CNT_BITS'(1);
              if (rdata_q.period != '0) begin
                mem_we              = 1'b1;
                mem_wdata.fire_time = rearm;
                cand                = rearm;
              end else begin
                valid_d[rd_idx_q] = 1'b0;
              end
            end
            keep = v && !(fired && (rdata_q.period == '0));
          end else begin
            // Set or stop: find the key and the first free slot; leave the
            // matched slot out of the minimum, it gets settled at commit.
            hit = v && nm && req_q.named && (rdata_q.key == req_q.key);
            if (hit) begin
              match_d     = 1'b1;
              match_idx_d = rd_idx_q;
              match_per_d = rdata_q.period;
            end
            if (!v && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
            keep = v && !hit;
          end
          if (keep) begin
            any_d = 1'b1;
            if (cand < min_q) begin
              min_d = cand;
            end
          end
        end
      end

      ktt_pkg::S_COMMIT: begin
        res_valid_d      = 1'b1;
        res_d.last       = 1'b1;
        res_d.any_active = any_q;
        res_d.next_fire  = min_q;
        if (req_q.operation == ktt_pkg::OP_STOP) begin
          if (match_q) begin
            valid_d[match_idx_q] = 1'b0;
            st = ktt_pkg::ST_UPDATED;
          end
        end else begin
          if (match_q) begin
            st = ktt_pkg::ST_UPDATED;
          end else if (free_q) begin
            st = ktt_pkg::ST_INSERTED;
          end else begin
            st = ktt_pkg::ST_FULL;
          end
          if (req_q.operation == ktt_pkg::OP_SET_PERIODIC) begin
            per_new = req_q.period;
          end else if (match_q) begin
            per_new = match_per_q;
          end
          if (ok) begin
            mem_we              = 1'b1;
            mem_waddr           = s;
            mem_wdata.key       = req_q.named ? req_q.key : '0;
            mem_wdata.fire_time = t_set;
            mem_wdata.period    = per_new;
            valid_d[s]          = 1'b1;
            named_d[s]          = req_q.named;
            res_d.any_active    = 1'b1;
            if (t_set < min_q) begin
              res_d.next_fire = t_set;
            end
          end
        end
        res_d.status = st;
      end

      ktt_pkg::S_EMIT: begin
        // Replay fired timers; report one empty result when none fired.
        res_valid_d      = 1'b1;
        res_d.status     = ktt_pkg::ST_NONE;
        res_d.any_active = any_q;
        res_d.next_fire  = min_q;
        res_d.last       = emit_last;
        if (fire_cnt_q != '0) begin
          res_d.fired_valid = 1'b1;
          res_d.fired_slot  = fifo_q[out_ptr_q].slot;
          res_d.fired_key   = fifo_q[out_ptr_q].key;
        end
        out_ptr_d = out_ptr_q + ktt_pkg::SLOT_BITS'(1);
      end

      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ktt_pkg::S_IDLE;
      valid_q     <= '0;
      named_q     <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      any_q       <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      fire_cnt_q  <= '0;
      out_ptr_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      named_q     <= named_d;
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      any_q       <= any_d;
      match_q     <= match_d;
      free_q      <= free_d;
      fire_cnt_q  <= fire_cnt_d;
      out_ptr_q   <= out_ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rd_idx_q    <= rd_idx_d;
    min_q       <= min_d;
    match_idx_q <= match_idx_d;
    match_per_q <= match_per_d;
    free_idx_q  <= free_idx_d;
    res_q       <= res_d;
    if (push) begin
      fifo_q[fire_cnt_q[ktt_pkg::SLOT_BITS-1:0]] <= push_data;
    end
  end

  // Table memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same slot in one cycle");

  a_fire_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= CNT_END)
    else $error("more fired timers than slots");

  a_insert_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ktt_pkg::S_COMMIT && !match_q && free_q) |-> !valid_q[free_idx_q])
    else $error("insert targets a slot that is in use");

  a_accept_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ktt_pkg::S_SCAN && cnt_q == '0))
    else $error("accepted command did not start a sweep");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.fired_valid) |-> res_q.last)
    else $error("result without a fired timer is not the final one");

  a_emit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ktt_pkg::S_EMIT || state_q == ktt_pkg::S_COMMIT) |=> res_valid_q)
    else $error("result missing after commit or replay cycle");

endmodule

`default_nettype wire
